// ----- hdl/vpcc_pkg.sv -----
`default_nettype none

package vpcc_pkg;

	localparam int MAX_QUEUES_DEF = 16;

	localparam int IN_W  = 48;
	localparam int OUT_W = 40;

	localparam int FEAT_W = 64;
	localparam int QC_W   = 5;
	localparam int QS_W   = 16;
	localparam int VC_W   = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_DEV_FEATURES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_QSIZE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_COUNT = 2'd3;

	localparam logic [1:0] WID_BYTE = 2'd0;
	localparam logic [1:0] WID_HALF = 2'd1;
	localparam logic [1:0] WID_WORD = 2'd2;

	localparam logic CMD_WRITE = 1'b1;

	localparam logic [5:0] OFF_DFEAT_SEL = 6'h00;
	localparam logic [5:0] OFF_DFEAT     = 6'h04;
	localparam logic [5:0] OFF_GFEAT_SEL = 6'h08;
	localparam logic [5:0] OFF_GFEAT     = 6'h0C;
	localparam logic [5:0] OFF_MSIX_CFG  = 6'h10;
	localparam logic [5:0] OFF_NUM_QUEUE = 6'h12;
	localparam logic [5:0] OFF_STATUS    = 6'h14;
	localparam logic [5:0] OFF_CFG_GEN   = 6'h15;
	localparam logic [5:0] OFF_QSEL      = 6'h16;
	localparam logic [5:0] OFF_QSIZE     = 6'h18;
	localparam logic [5:0] OFF_QVECTOR   = 6'h1A;
	localparam logic [5:0] OFF_QENABLE   = 6'h1C;
	localparam logic [5:0] OFF_QNOTIFY   = 6'h1E;
	localparam logic [5:0] OFF_QDESC_LO  = 6'h20;
	localparam logic [5:0] OFF_QDESC_HI  = 6'h24;
	localparam logic [5:0] OFF_QDRV_LO   = 6'h28;
	localparam logic [5:0] OFF_QDRV_HI   = 6'h2C;
	localparam logic [5:0] OFF_QDEV_LO   = 6'h30;
	localparam logic [5:0] OFF_QDEV_HI   = 6'h34;

	localparam logic [15:0] VEC_NONE        = 16'hFFFF;
	localparam int          FEATURES_OK_BIT = 3;
	localparam int          VERSION_1_BIT   = 32;

	localparam logic [FEAT_W-1:0] DEV_FEATURES_RST = 64'h0000_0001_0000_0000;
	localparam logic [QC_W-1:0]   QUEUE_COUNT_RST  = 5'd1;
	localparam logic [QS_W-1:0]   MAX_QSIZE_RST    = 16'd256;
	localparam logic [VC_W-1:0]   VECTOR_COUNT_RST = 12'd1;

	typedef struct packed {
		logic [15:0] size;
		logic [15:0] vector;
		logic        enable;
		logic [63:0] desc;
		logic [63:0] avail;
		logic [63:0] used;
	} qent_t;

	// Bit 2 says a register starts at the offset, bits 1:0 give its width code.
	function automatic logic [2:0] width_at(input logic [5:0] off);
		logic [2:0] res;
		if (off < 6'h10) begin
			res = (off[1:0] != 2'b00) ? 3'b000 : {1'b1, WID_WORD};
		end else if (off < 6'h14) begin
			res = off[0] ? 3'b000 : {1'b1, WID_HALF};
		end else if (off < 6'h16) begin
			res = {1'b1, WID_BYTE};
		end else if (off < 6'h20) begin
			res = off[0] ? 3'b000 : {1'b1, WID_HALF};
		end else if (off < 6'h38) begin
			res = (off[1:0] != 2'b00) ? 3'b000 : {1'b1, WID_WORD};
		end else begin
			res = 3'b000;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/vpcc_qmem.sv -----
`default_nettype none

module vpcc_qmem #(
	parameter int MAX_QUEUES = vpcc_pkg::MAX_QUEUES_DEF,
	parameter int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [QW-1:0]            rd_addr,
	output vpcc_pkg::qent_t               rd_data,
	input  wire logic                     wr_en,
	input  wire logic [QW-1:0]            wr_addr,
	input  vpcc_pkg::qent_t               wr_data,
	input  wire logic                     clr_all,
	input  wire logic                     clr_size,
	input  wire logic [vpcc_pkg::QS_W-1:0] max_qsize
);
	import vpcc_pkg::*;

	qent_t mem_q [MAX_QUEUES];
	qent_t mem_rd_q;
	qent_t byp_data_q;
	qent_t raw;
	logic  byp_q;
	logic  ev_q;
	logic  sv_q;

	logic [MAX_QUEUES-1:0] ent_valid_q;
	logic [MAX_QUEUES-1:0] size_valid_q;
	logic [MAX_QUEUES-1:0] ent_valid_d;
	logic [MAX_QUEUES-1:0] size_valid_d;

	always_comb begin
		ent_valid_d  = ent_valid_q;
		size_valid_d = size_valid_q;
		if (clr_all) begin
			ent_valid_d  = '0;
			size_valid_d = '0;
		end
		if (clr_size) begin
			size_valid_d = '0;
		end
		if (wr_en) begin
			ent_valid_d[wr_addr]  = 1'b1;
			size_valid_d[wr_addr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q  <= '0;
			size_valid_q <= '0;
			byp_q        <= 1'b0;
			ev_q         <= 1'b0;
			sv_q         <= 1'b0;
		end else begin
			ent_valid_q  <= ent_valid_d;
			size_valid_q <= size_valid_d;
			if (rd_en) begin
				byp_q <= wr_en && (wr_addr == rd_addr);
				ev_q  <= ent_valid_d[rd_addr];
				sv_q  <= size_valid_d[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem_q[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	always_comb begin
		raw = byp_q ? byp_data_q : mem_rd_q;
		if (!ev_q) begin
			rd_data        = '0;
			rd_data.vector = VEC_NONE;
			rd_data.size   = max_qsize;
		end else begin
			rd_data = raw;
			if (!sv_q) begin
				rd_data.size = max_qsize;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/virtio_pci_common_config_regs_top.sv -----
// Device side of the virtio 1.0 PCI common configuration window.
// The slave stream carries one bus access per transfer: a read or a write of
// one, two or four bytes at a byte offset in the 64-byte window. The master
// stream returns exactly one transfer per access, holding the read data (zero
// for writes and errors) and an access error flag. Device parameters (offered
// features, queue count, maximum ring size, vector count) are to be set by the
// user through the configuration write port only while no access is in flight;
// the block itself does not enforce this. An access passes through the input
// register, while the per-queue entry is read from the queue memory, and then
// through the result register. One access is accepted every cycle as long as
// the receiver takes results; the queue memory read port sets that pace.
// When the receiver stalls, the result register holds and one more access
// waits in the input register; then s_tready drops until the result moves.
// Reset restores the configuration defaults and clears all driver state.
// Writing zero to device status clears the driver state the same way.

`default_nettype none

module virtio_pci_common_config_regs_top #(
	parameter int MAX_QUEUES = vpcc_pkg::MAX_QUEUES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// command[0], offset[6:1], access_width[8:7], write_data[40:9], zero fill
	input  wire logic [vpcc_pkg::IN_W-1:0]        s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// read_data[31:0], access_error[32], zero fill
	output logic [vpcc_pkg::OUT_W-1:0]            m_tdata,
	input  wire logic                             cfg_wr_en,
	input  wire logic [vpcc_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [vpcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import vpcc_pkg::*;

	localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int LW = ($clog2(MAX_QUEUES + 1) > QC_W) ? $clog2(MAX_QUEUES + 1) : QC_W;

	logic [FEAT_W-1:0] dev_feat_q;
	logic [QC_W-1:0]   qcount_q;
	logic [QS_W-1:0]   max_qsize_q;
	logic [VC_W-1:0]   vcount_q;

	logic [31:0] dfw_q, dfw_d;
	logic [31:0] gfw_q, gfw_d;
	logic [63:0] drv_feat_q, drv_feat_d;
	logic [15:0] cfg_vec_q, cfg_vec_d;
	logic [7:0]  status_q, status_d;
	logic [15:0] sel_q, sel_d;

	logic        valid_s1;
	logic        cmd_s1;
	logic [5:0]  off_s1;
	logic [1:0]  wid_s1;
	logic [31:0] wd_s1;

	logic        out_valid_q;
	logic [31:0] rdata_s2;
	logic        err_s2;

	logic        adv;
	logic [2:0]  wa;
	logic        acc_err;
	logic [31:0] dm;
	logic [31:0] rdata;
	logic [15:0] vtake;
	logic        feat_ok;
	logic [LW-1:0] live;
	logic        qv;
	logic        q_wr;
	logic        clr_all;
	logic        clr_size;
	qent_t       ent;
	qent_t       ent_new;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - 33){1'b0}}, err_s2, rdata_s2};
	assign clr_size = cfg_wr_en && (cfg_addr == CFG_MAX_QSIZE);

	vpcc_qmem #(
		.MAX_QUEUES(MAX_QUEUES),
		.QW(QW)
	) u_qmem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(s_tvalid && s_tready),
		.rd_addr(sel_d[QW-1:0]),
		.rd_data(ent),
		.wr_en(q_wr),
		.wr_addr(sel_q[QW-1:0]),
		.wr_data(ent_new),
		.clr_all(clr_all),
		.clr_size(clr_size),
		.max_qsize(max_qsize_q)
	);

	always_comb begin
		live = (LW'(qcount_q) < LW'(MAX_QUEUES)) ? LW'(qcount_q) : LW'(MAX_QUEUES);
		qv   = sel_q < 16'(live);
		wa   = width_at(off_s1);
		acc_err = !wa[2] || (wa[1:0] != wid_s1);
		case (wid_s1)
			WID_BYTE: dm = {24'b0, wd_s1[7:0]};
			WID_HALF: dm = {16'b0, wd_s1[15:0]};
			default:  dm = wd_s1;
		endcase
		vtake = ((dm[15:0] == VEC_NONE) || (dm[15:0] < {4'b0, vcount_q})) ? dm[15:0] : VEC_NONE;
		feat_ok = ((drv_feat_q & ~dev_feat_q) == '0) && drv_feat_q[VERSION_1_BIT];

		dfw_d      = dfw_q;
		gfw_d      = gfw_q;
		drv_feat_d = drv_feat_q;
		cfg_vec_d  = cfg_vec_q;
		status_d   = status_q;
		sel_d      = sel_q;
		ent_new    = ent;
		q_wr       = 1'b0;
		clr_all    = 1'b0;
		rdata      = '0;

		if (adv && !acc_err) begin
			if (cmd_s1 == CMD_WRITE) begin
				unique case (off_s1)
					OFF_DFEAT_SEL: dfw_d = dm;
					OFF_GFEAT_SEL: gfw_d = dm;
					OFF_GFEAT: begin
						if (gfw_q == 32'd0) begin
							drv_feat_d[31:0] = dm;
						end else if (gfw_q == 32'd1) begin
							drv_feat_d[63:32] = dm;
						end
					end
					OFF_MSIX_CFG: cfg_vec_d = vtake;
					OFF_STATUS: begin
						if (dm[7:0] == 8'd0) begin
							clr_all    = 1'b1;
							dfw_d      = '0;
							gfw_d      = '0;
							drv_feat_d = '0;
							cfg_vec_d  = VEC_NONE;
							status_d   = '0;
							sel_d      = '0;
						end else begin
							status_d = dm[7:0];
							if (!feat_ok) begin
								status_d[FEATURES_OK_BIT] = 1'b0;
							end
						end
					end
					OFF_QSEL: sel_d = dm[15:0];
					OFF_QSIZE: begin
						q_wr = qv;
						if ((dm[15:0] != 16'd0) && (dm[15:0] <= max_qsize_q)) begin
							ent_new.size = dm[15:0];
						end
					end
					OFF_QVECTOR: begin
						q_wr = qv;
						ent_new.vector = vtake;
					end
					OFF_QENABLE: begin
						q_wr = qv;
						if (dm[15:0] != 16'd0) begin
							ent_new.enable = 1'b1;
						end
					end
					OFF_QDESC_LO: begin
						q_wr = qv;
						ent_new.desc[31:0] = dm;
					end
					OFF_QDESC_HI: begin
						q_wr = qv;
						ent_new.desc[63:32] = dm;
					end
					OFF_QDRV_LO: begin
						q_wr = qv;
						ent_new.avail[31:0] = dm;
					end
					OFF_QDRV_HI: begin
						q_wr = qv;
						ent_new.avail[63:32] = dm;
					end
					OFF_QDEV_LO: begin
						q_wr = qv;
						ent_new.used[31:0] = dm;
					end
					OFF_QDEV_HI: begin
						q_wr = qv;
						ent_new.used[63:32] = dm;
					end
					default: ;
				endcase
			end else begin
				unique case (off_s1)
					OFF_DFEAT_SEL: rdata = dfw_q;
					OFF_DFEAT: begin
						if (dfw_q == 32'd0) begin
							rdata = dev_feat_q[31:0];
						end else if (dfw_q == 32'd1) begin
							rdata = dev_feat_q[63:32];
						end
					end
					OFF_GFEAT_SEL: rdata = gfw_q;
					OFF_GFEAT: begin
						if (gfw_q == 32'd0) begin
							rdata = drv_feat_q[31:0];
						end else if (gfw_q == 32'd1) begin
							rdata = drv_feat_q[63:32];
						end
					end
					OFF_MSIX_CFG:  rdata = {16'b0, cfg_vec_q};
					OFF_NUM_QUEUE: rdata = 32'(live);
					OFF_STATUS:    rdata = {24'b0, status_q};
					OFF_CFG_GEN:   rdata = '0;
					OFF_QSEL:      rdata = {16'b0, sel_q};
					OFF_QSIZE:     rdata = qv ? {16'b0, ent.size} : '0;
					OFF_QVECTOR:   rdata = qv ? {16'b0, ent.vector} : '0;
					OFF_QENABLE:   rdata = {31'b0, qv && ent.enable};
					OFF_QNOTIFY:   rdata = qv ? {16'b0, sel_q} : '0;
					OFF_QDESC_LO:  rdata = qv ? ent.desc[31:0] : '0;
					OFF_QDESC_HI:  rdata = qv ? ent.desc[63:32] : '0;
					OFF_QDRV_LO:   rdata = qv ? ent.avail[31:0] : '0;
					OFF_QDRV_HI:   rdata = qv ? ent.avail[63:32] : '0;
					OFF_QDEV_LO:   rdata = qv ? ent.used[31:0] : '0;
					OFF_QDEV_HI:   rdata = qv ? ent.used[63:32] : '0;
					default:       rdata = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_feat_q  <= DEV_FEATURES_RST;
			qcount_q    <= QUEUE_COUNT_RST;
			max_qsize_q <= MAX_QSIZE_RST;
			vcount_q    <= VECTOR_COUNT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_DEV_FEATURES: dev_feat_q  <= cfg_wdata;
				CFG_QUEUE_COUNT:  qcount_q    <= cfg_wdata[QC_W-1:0];
				CFG_MAX_QSIZE:    max_qsize_q <= cfg_wdata[QS_W-1:0];
				CFG_VECTOR_COUNT: vcount_q    <= cfg_wdata[VC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dfw_q       <= '0;
			gfw_q       <= '0;
			drv_feat_q  <= '0;
			cfg_vec_q   <= VEC_NONE;
			status_q    <= '0;
			sel_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			dfw_q      <= dfw_d;
			gfw_q      <= gfw_d;
			drv_feat_q <= drv_feat_d;
			cfg_vec_q  <= cfg_vec_d;
			status_q   <= status_d;
			sel_q      <= sel_d;
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tdata[0];
			off_s1 <= s_tdata[6:1];
			wid_s1 <= s_tdata[8:7];
			wd_s1  <= s_tdata[40:9];
		end
		if (adv) begin
			rdata_s2 <= rdata;
			err_s2   <= acc_err;
		end
	end

endmodule

`default_nettype wire

// ----- bench/tb_virtio_pci_common_config_regs_top.sv -----
`default_nettype none

module tb_virtio_pci_common_config_regs_top;
	import vpcc_pkg::*;

	localparam int NQ = MAX_QUEUES_DEF;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic CMD_READ = 1'b0;
	localparam logic [1:0] WID_BAD = 2'd3;

	localparam logic [7:0] STAT_ACK = 8'h01;
	localparam logic [7:0] STAT_DRIVER = 8'h02;
	localparam logic [7:0] STAT_DRIVER_OK = 8'h04;
	localparam logic [7:0] STAT_FEATURES_OK = 8'h08;

	typedef struct packed {
		logic [31:0] read_data;
		logic access_error;
	} access_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Device parameters as the block should hold them.
	logic [FEAT_W-1:0] feat_offer;
	logic [QC_W-1:0] queue_total;
	logic [QS_W-1:0] ring_limit;
	logic [VC_W-1:0] vec_total;

	// Driver-visible register state.
	logic [31:0] dev_sel;
	logic [31:0] drv_sel;
	logic [63:0] drv_feat;
	logic [15:0] cfg_vec;
	logic [7:0] dev_status;
	logic [15:0] sel_queue;
	logic [15:0] ring_size [NQ];
	logic [15:0] ring_vec [NQ];
	logic ring_en [NQ];
	// First index: descriptor, driver and device area, in window order.
	logic [63:0] ring_addr [3][NQ];

	access_result_t pending_results[$];
	int items_sent = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int rx_hold_cycles = 0;
	logic no_gaps = 1'b0;

	virtio_pci_common_config_regs_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_driver_state();
		dev_sel = '0;
		drv_sel = '0;
		drv_feat = '0;
		cfg_vec = VEC_NONE;
		dev_status = '0;
		sel_queue = '0;
		for (int i = 0; i < NQ; i++) begin
			ring_size[i] = ring_limit;
			ring_vec[i] = VEC_NONE;
			ring_en[i] = 1'b0;
			for (int k = 0; k < 3; k++) ring_addr[k][i] = '0;
		end
	endfunction

	function automatic logic [4:0] live_count();
		return (queue_total < NQ) ? 5'(queue_total) : 5'(NQ);
	endfunction

	function automatic int reg_width(input logic [5:0] off);
		case (off)
			OFF_DFEAT_SEL, OFF_DFEAT, OFF_GFEAT_SEL, OFF_GFEAT,
			OFF_QDESC_LO, OFF_QDESC_HI, OFF_QDRV_LO, OFF_QDRV_HI,
			OFF_QDEV_LO, OFF_QDEV_HI: return int'(WID_WORD);
			OFF_MSIX_CFG, OFF_NUM_QUEUE, OFF_QSEL, OFF_QSIZE,
			OFF_QVECTOR, OFF_QENABLE, OFF_QNOTIFY: return int'(WID_HALF);
			OFF_STATUS, OFF_CFG_GEN: return int'(WID_BYTE);
			default: return -1;
		endcase
	endfunction

	function automatic logic [15:0] clamp_vector(input logic [15:0] v);
		return (v == VEC_NONE || v < vec_total) ? v : VEC_NONE;
	endfunction

	function automatic access_result_t predict_access(input logic cmd, input logic [5:0] off,
			input logic [1:0] wid, input logic [31:0] wdata);
		access_result_t r;
		logic [31:0] d;
		logic present;
		int q;
		int area;
		logic [7:0] st;
		r.read_data = '0;
		r.access_error = 1'b0;
		present = sel_queue < live_count();
		q = present ? int'(sel_queue) : 0;
		if (reg_width(off) != int'(wid)) begin
			r.access_error = 1'b1;
			return r;
		end
		d = wdata;
		if (wid == WID_BYTE) d = d & 32'h0000_00FF;
		else if (wid == WID_HALF) d = d & 32'h0000_FFFF;
		if (off >= OFF_QDESC_LO) begin
			area = int'(off[4:3]);
			if (present) begin
				if (cmd == CMD_WRITE) begin
					if (off[2]) ring_addr[area][q][63:32] = d;
					else ring_addr[area][q][31:0] = d;
				end else begin
					r.read_data = off[2] ? ring_addr[area][q][63:32] : ring_addr[area][q][31:0];
				end
			end
		end else if (cmd == CMD_WRITE) begin
			case (off)
				OFF_DFEAT_SEL: dev_sel = d;
				OFF_GFEAT_SEL: drv_sel = d;
				OFF_GFEAT: begin
					if (drv_sel == 0) drv_feat[31:0] = d;
					else if (drv_sel == 1) drv_feat[63:32] = d;
				end
				OFF_MSIX_CFG: cfg_vec = clamp_vector(d[15:0]);
				OFF_STATUS: begin
					st = d[7:0];
					if (st == 0) begin
						clear_driver_state();
					end else begin
						if (st[FEATURES_OK_BIT] && (((drv_feat & ~feat_offer) != 0) ||
								!drv_feat[VERSION_1_BIT]))
							st[FEATURES_OK_BIT] = 1'b0;
						dev_status = st;
					end
				end
				OFF_QSEL: sel_queue = d[15:0];
				OFF_QSIZE: begin
					if (present && d[15:0] != 0 && d[15:0] <= ring_limit) ring_size[q] = d[15:0];
				end
				OFF_QVECTOR: if (present) ring_vec[q] = clamp_vector(d[15:0]);
				OFF_QENABLE: if (present && d != 0) ring_en[q] = 1'b1;
				default: ;
			endcase
		end else begin
			case (off)
				OFF_DFEAT_SEL: r.read_data = dev_sel;
				OFF_DFEAT: begin
					if (dev_sel == 0) r.read_data = feat_offer[31:0];
					else if (dev_sel == 1) r.read_data = feat_offer[63:32];
				end
				OFF_GFEAT_SEL: r.read_data = drv_sel;
				OFF_GFEAT: begin
					if (drv_sel == 0) r.read_data = drv_feat[31:0];
					else if (drv_sel == 1) r.read_data = drv_feat[63:32];
				end
				OFF_MSIX_CFG: r.read_data = 32'(cfg_vec);
				OFF_NUM_QUEUE: r.read_data = 32'(live_count());
				OFF_STATUS: r.read_data = 32'(dev_status);
				OFF_QSEL: r.read_data = 32'(sel_queue);
				OFF_QSIZE: r.read_data = present ? 32'(ring_size[q]) : 32'd0;
				OFF_QVECTOR: r.read_data = present ? 32'(ring_vec[q]) : 32'd0;
				OFF_QENABLE: r.read_data = 32'(present && ring_en[q]);
				OFF_QNOTIFY: r.read_data = 32'(q);
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [31:0] pick_queue();
		case ($urandom_range(0, 9))
			7: return 32'(NQ - 1);
			8: return 32'(VEC_NONE);
			9: return $urandom_range(0, 16'hFFFF);
			default: return $urandom_range(0, live_count());
		endcase
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'(ring_limit);
			2: return 32'(ring_limit) + 32'd1;
			3: return 32'd1;
			default: return $urandom_range(1, ring_limit);
		endcase
	endfunction

	function automatic logic [31:0] pick_vector();
		case ($urandom_range(0, 7))
			0: return 32'(VEC_NONE);
			1: return 32'(vec_total);
			2: return 32'(16'(vec_total - 1'b1));
			3: return 32'd0;
			4: return $urandom_range(0, 16'hFFFF);
			default: return $urandom_range(0, int'(vec_total) + 2);
		endcase
	endfunction

	function automatic logic [5:0] pick_register();
		case ($urandom_range(0, 17))
			0: return OFF_DFEAT_SEL;
			1: return OFF_DFEAT;
			2: return OFF_GFEAT_SEL;
			3: return OFF_GFEAT;
			4: return OFF_MSIX_CFG;
			5: return OFF_NUM_QUEUE;
			6: return OFF_STATUS;
			7: return OFF_CFG_GEN;
			8: return OFF_QSEL;
			9: return OFF_QSIZE;
			10: return OFF_QVECTOR;
			11: return OFF_QENABLE;
			12: return OFF_QNOTIFY;
			13: return OFF_QDESC_LO;
			14: return OFF_QDESC_HI;
			15: return OFF_QDRV_LO;
			16: return OFF_QDRV_HI;
			default: return OFF_QDEV_LO + 6'(4 * $urandom_range(0, 1));
		endcase
	endfunction

	task automatic send_access(input logic cmd, input logic [5:0] off, input logic [1:0] wid,
			input logic [31:0] data);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, data, wid, off, cmd};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_access(cmd, off, wid, data));
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_param(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
		case (idx)
			CFG_DEV_FEATURES: feat_offer = v;
			CFG_QUEUE_COUNT: queue_total = v[QC_W-1:0];
			CFG_MAX_QSIZE: begin
				ring_limit = v[QS_W-1:0];
				for (int i = 0; i < NQ; i++) ring_size[i] = ring_limit;
			end
			default: vec_total = v[VC_W-1:0];
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [63:0] feats, input int qcount, input int qsize,
			input int vcount);
		wait_idle();
		write_param(CFG_DEV_FEATURES, feats);
		write_param(CFG_QUEUE_COUNT, 64'(qcount));
		write_param(CFG_MAX_QSIZE, 64'(qsize));
		write_param(CFG_VECTOR_COUNT, 64'(vcount));
	endtask

	task automatic send_register_access();
		logic cmd;
		logic [5:0] off;
		logic [1:0] wid;
		logic [31:0] d;
		if ($urandom_range(0, 3) == 0) begin
			send_access(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
					2'($urandom_range(0, 3)), $urandom);
			return;
		end
		cmd = 1'($urandom_range(0, 1));
		off = pick_register();
		wid = 2'(reg_width(off));
		case (off)
			OFF_DFEAT_SEL, OFF_GFEAT_SEL:
				d = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2);
			OFF_GFEAT: d = $urandom_range(0, 1) ? $urandom :
					((drv_sel == 1) ? feat_offer[63:32] : feat_offer[31:0]);
			OFF_MSIX_CFG, OFF_QVECTOR: d = pick_vector();
			OFF_STATUS: d = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 255);
			OFF_QSEL: d = pick_queue();
			OFF_QSIZE: d = pick_size();
			OFF_QENABLE: d = $urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 16'hFFFF);
			default: d = $urandom;
		endcase
		// Narrow writes carry junk in the unused upper bytes now and then.
		if (wid == WID_BYTE && $urandom_range(0, 1)) d[31:8] = 24'($urandom);
		if (wid == WID_HALF && $urandom_range(0, 1)) d[31:16] = 16'($urandom);
		send_access(cmd, off, wid, d);
	endtask

	// A driver bring-up as the specification orders it, with random content.
	task automatic run_bringup();
		logic [63:0] want;
		logic [31:0] q;
		send_access(CMD_WRITE, OFF_STATUS, WID_BYTE, 32'd0);
		send_access(CMD_WRITE, OFF_STATUS, WID_BYTE, 32'(STAT_ACK));
		send_access(CMD_WRITE, OFF_STATUS, WID_BYTE, 32'(STAT_ACK | STAT_DRIVER));
		for (int h = 0; h < 2; h++) begin
			send_access(CMD_WRITE, OFF_DFEAT_SEL, WID_WORD, 32'(h));
			send_access(CMD_READ, OFF_DFEAT, WID_WORD, $urandom);
		end
		case ($urandom_range(0, 3))
			0: want = {$urandom, $urandom};
			1: want = feat_offer;
			default: want = (feat_offer & {$urandom, $urandom}) | (64'd1 << VERSION_1_BIT);
		endcase
		for (int h = 0; h < 2; h++) begin
			send_access(CMD_WRITE, OFF_GFEAT_SEL, WID_WORD, 32'(h));
			send_access(CMD_WRITE, OFF_GFEAT, WID_WORD, h ? want[63:32] : want[31:0]);
		end
		send_access(CMD_WRITE, OFF_STATUS, WID_BYTE,
				32'(STAT_ACK | STAT_DRIVER | STAT_FEATURES_OK));
		send_access(CMD_READ, OFF_STATUS, WID_BYTE, $urandom);
		send_access(CMD_READ, OFF_NUM_QUEUE, WID_HALF, $urandom);
		repeat ($urandom_range(1, 3)) begin
			q = pick_queue();
			send_access(CMD_WRITE, OFF_QSEL, WID_HALF, q);
			send_access(CMD_READ, OFF_QSIZE, WID_HALF, $urandom);
			send_access(CMD_WRITE, OFF_QSIZE, WID_HALF, pick_size());
			send_access(CMD_WRITE, OFF_QVECTOR, WID_HALF, pick_vector());
			for (int k = 0; k < 6; k++)
				send_access(CMD_WRITE, OFF_QDESC_LO + 6'(4 * k), WID_WORD, $urandom);
			send_access(CMD_READ, OFF_QDESC_LO + 6'(4 * $urandom_range(0, 5)), WID_WORD, $urandom);
			send_access(CMD_WRITE, OFF_QENABLE, WID_HALF, 32'd1);
			send_access(CMD_READ, OFF_QENABLE, WID_HALF, $urandom);
			send_access(CMD_READ, OFF_QNOTIFY, WID_HALF, $urandom);
			send_access(CMD_READ, OFF_QVECTOR, WID_HALF, $urandom);
		end
		send_access(CMD_WRITE, OFF_MSIX_CFG, WID_HALF, pick_vector());
		send_access(CMD_READ, OFF_MSIX_CFG, WID_HALF, $urandom);
		send_access(CMD_WRITE, OFF_STATUS, WID_BYTE,
				32'(STAT_ACK | STAT_DRIVER | STAT_FEATURES_OK | STAT_DRIVER_OK));
		send_access(CMD_READ, OFF_STATUS, WID_BYTE, $urandom);
	endtask

	task automatic run_traffic(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
			if ($urandom_range(0, 11) == 0) run_bringup();
			else send_register_access();
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_feature_windows();
		send_access(CMD_READ, OFF_DFEAT, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_WRITE, OFF_DFEAT_SEL, WID_WORD, 32'd1);
		send_access(CMD_READ, OFF_DFEAT, WID_WORD, 32'd0);
		send_access(CMD_WRITE, OFF_GFEAT_SEL, WID_WORD, 32'd1);
		send_access(CMD_WRITE, OFF_GFEAT, WID_WORD, 32'd1);
		send_access(CMD_WRITE, OFF_DFEAT_SEL, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_READ, OFF_DFEAT, WID_WORD, 32'd0);
		send_access(CMD_WRITE, OFF_GFEAT_SEL, WID_WORD, 32'd2);
		send_access(CMD_WRITE, OFF_GFEAT, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_READ, OFF_GFEAT, WID_WORD, 32'd0);
	endtask

	task automatic test_status_and_vectors();
		send_access(CMD_WRITE, OFF_STATUS, WID_BYTE,
				32'(STAT_ACK | STAT_DRIVER | STAT_FEATURES_OK));
		send_access(CMD_READ, OFF_STATUS, WID_BYTE, 32'd0);
		send_access(CMD_WRITE, OFF_MSIX_CFG, WID_HALF, 32'd1);
		send_access(CMD_READ, OFF_MSIX_CFG, WID_HALF, 32'd0);
	endtask

	task automatic test_queue_registers();
		send_access(CMD_WRITE, OFF_QSIZE, WID_HALF, 32'd0);
		send_access(CMD_WRITE, OFF_QSIZE, WID_HALF, 32'(MAX_QSIZE_RST) + 32'd1);
		send_access(CMD_READ, OFF_QSIZE, WID_HALF, 32'd0);
		send_access(CMD_WRITE, OFF_QENABLE, WID_HALF, 32'd0);
		send_access(CMD_READ, OFF_QENABLE, WID_HALF, 32'd0);
		send_access(CMD_WRITE, OFF_QSEL, WID_HALF, 32'd1);
		send_access(CMD_READ, OFF_QNOTIFY, WID_HALF, 32'd0);
	endtask

	task automatic test_bad_accesses();
		send_access(CMD_READ, OFF_DFEAT_SEL + 6'd2, WID_WORD, 32'd0);
		send_access(CMD_WRITE, OFF_NUM_QUEUE, WID_HALF, 32'hFFFF);
		send_access(CMD_WRITE, 6'h3F, WID_BAD, 32'hFFFF_FFFF);
		send_access(CMD_WRITE, OFF_STATUS, WID_BYTE, 32'd0);
		send_access(CMD_READ, OFF_QSEL, WID_HALF, 32'd0);
	endtask

	task automatic test_setting_extremes();
		apply_settings(64'd0, 0, 1, 0);
		run_traffic(120);
		apply_settings('1, NQ, 32768, 2048);
		run_traffic(140);
	endtask

	task automatic test_random_settings();
		logic [63:0] feats;
		repeat (4) begin
			feats = {$urandom, $urandom};
			if ($urandom_range(0, 1)) feats[VERSION_1_BIT] = 1'b1;
			apply_settings(feats, $urandom_range(0, NQ),
					$urandom_range(0, 3) ? $urandom_range(1, 64) : $urandom_range(1, 32768),
					$urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 2048));
			run_traffic(130);
		end
	endtask

	// The receiver stops long enough for the block to fill and hold off the sender.
	task automatic test_backpressure();
		wait_idle();
		no_gaps = 1'b1;
		rx_hold_cycles = 200;
		repeat (40) send_register_access();
		no_gaps = 1'b0;
	endtask

	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				rx_hold_cycles--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no access waiting: read_data %h access_error %b",
						m_tdata[31:0], m_tdata[32]);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.read_data) begin
					$error("read_data mismatch: expected %h, actual %h",
							want.read_data, m_tdata[31:0]);
					mismatch_count++;
				end
				if (m_tdata[32] !== want.access_error) begin
					$error("access_error mismatch: expected %b, actual %b",
							want.access_error, m_tdata[32]);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("virtio_pci_common_config_regs_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		feat_offer = DEV_FEATURES_RST;
		queue_total = QUEUE_COUNT_RST;
		ring_limit = MAX_QSIZE_RST;
		vec_total = VECTOR_COUNT_RST;
		clear_driver_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_feature_windows();
		test_status_and_vectors();
		test_queue_registers();
		test_bad_accesses();
		test_setting_extremes();
		test_random_settings();
		test_backpressure();

		wait_idle();
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("virtio_pci_common_config_regs_top verification clean");
		end else begin
			$display("virtio_pci_common_config_regs_top verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- virtio_pci_common_config_regs_top.f -----
hdl/vpcc_pkg.sv
hdl/vpcc_qmem.sv
hdl/virtio_pci_common_config_regs_top.sv
bench/tb_virtio_pci_common_config_regs_top.sv
